[rtl/smbpec_pkg.sv]
// Shared types, codes and the CRC-8 helper of the SMBus word master with PEC.
// No dependencies; every other file but the checker imports this package.
package smbpec_pkg;

  localparam int unsigned PHASE_W   = 10;
  localparam int unsigned RETRY_W   = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = CFG_IDX_W'(1);

  localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = PHASE_W'(20);
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = RETRY_W'(254);

  localparam logic [7:0] CRC_POLY = 8'h07;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_STOP0    = 5'd1,
    PH_STOP1    = 5'd2,
    PH_STOP2    = 5'd3,
    PH_START0   = 5'd4,
    PH_START1   = 5'd5,
    PH_TXLOW    = 5'd6,
    PH_TXHIGH   = 5'd7,
    PH_ACKLOW   = 5'd8,
    PH_ACKHIGH  = 5'd9,
    PH_RXLOW    = 5'd10,
    PH_RXHIGH   = 5'd11,
    PH_MACKLOW  = 5'd12,
    PH_MACKHIGH = 5'd13,
    PH_RSTART   = 5'd14,
    PH_END0     = 5'd15,
    PH_END1     = 5'd16,
    PH_END2     = 5'd17
  } phase_e;

  typedef enum logic [1:0] {
    FIN_NONE = 2'd0,
    FIN_OK   = 2'd1,
    FIN_FAIL = 2'd2
  } fin_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] slave_addr;
    logic [7:0] register_code;
    logic [7:0] write_low;
    logic [7:0] write_high;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic        failed;
    logic [15:0] read_word;
  } result_t;

  // effective settings, zero already mapped to one
  typedef struct packed {
    logic [PHASE_W-1:0] phase_ticks;
    logic [RETRY_W-1:0] retry_limit;
  } cfg_t;

  // SMBus PEC: CRC-8, poly x^8+x^2+x+1, MSB first
  function automatic logic [7:0] crc8_upd(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[rtl/smbpec_if.sv]
// Valid/ready channel interfaces: tick words in, result words out, config writes.
// Depends on smbpec_pkg.
interface smbpec_in_if import smbpec_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [6:0] slave_addr;
  logic [7:0] register_code;
  logic [7:0] write_low;
  logic [7:0] write_high;
  logic       sda_in;

  modport source (output valid, cmd, slave_addr, register_code, write_low, write_high,
                  sda_in, input ready);
  modport sink   (input valid, cmd, slave_addr, register_code, write_low, write_high,
                  sda_in, output ready);
endinterface

interface smbpec_out_if import smbpec_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        scl_out;
  logic        sda_out;
  logic        busy_res;
  logic        done_res;
  logic        failed;
  logic [15:0] read_word;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, failed, read_word,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, failed, read_word,
                  output ready);
endinterface

interface smbpec_cfg_if import smbpec_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/smbpec_cfg.sv]
// Configuration registers (phase length, retry limit) with zero mapped to one.
// Depends on smbpec_pkg.
module smbpec_cfg import smbpec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  logic [CFG_IDX_W-1:0] index_i,
  input  logic [CFG_DAT_W-1:0] data_i,
  output cfg_t                 cfg_o
);

  logic [PHASE_W-1:0] phase_q;
  logic [RETRY_W-1:0] retry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_TICKS_RST;
      retry_q <= RETRY_LIMIT_RST;
    end else if (wr_i) begin
      if (index_i == CFG_PHASE_TICKS) phase_q <= data_i[PHASE_W-1:0];
      if (index_i == CFG_RETRY_LIMIT) retry_q <= data_i[RETRY_W-1:0];
    end
  end

  assign cfg_o.phase_ticks = (phase_q == '0) ? PHASE_W'(1) : phase_q;
  assign cfg_o.retry_limit = (retry_q == '0) ? RETRY_W'(1) : retry_q;

endmodule

[rtl/smbpec_core.sv]
// Bus sequencer state and its one-tick update; result is combinational from
// the next state. Depends on smbpec_pkg.
module smbpec_core import smbpec_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  phase_e             ph_q, ph_d;
  logic [PHASE_W-1:0] tk_q, tk_d;
  logic [3:0]         bc_q, bc_d;
  logic [7:0]         sb_q, sb_d;
  logic [7:0]         crc_q, crc_d;
  logic [RETRY_W-1:0] att_q, att_d;
  logic [7:0]         code_q, code_d;
  logic [7:0]         lo_q, lo_d;
  logic [7:0]         hi_q, hi_d;
  logic [6:0]         addr_q, addr_d;
  logic               rd_q, rd_d;
  logic               ff_q, ff_d;
  logic [15:0]        dw_q, dw_d;
  logic [2:0]         bi_q, bi_d;

  fin_e       fin;
  logic       do_adv, do_load, do_fail, fail_end;
  logic [7:0] tx_byte;
  logic       tx_pec;
  logic [7:0] rx_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      tk_q   <= '0;
      bc_q   <= '0;
      sb_q   <= '0;
      crc_q  <= '0;
      att_q  <= '0;
      code_q <= '0;
      lo_q   <= '0;
      hi_q   <= '0;
      addr_q <= '0;
      rd_q   <= 1'b0;
      ff_q   <= 1'b0;
      dw_q   <= '0;
      bi_q   <= '0;
    end else if (step_i) begin
      ph_q   <= ph_d;
      tk_q   <= tk_d;
      bc_q   <= bc_d;
      sb_q   <= sb_d;
      crc_q  <= crc_d;
      att_q  <= att_d;
      code_q <= code_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      addr_q <= addr_d;
      rd_q   <= rd_d;
      ff_q   <= ff_d;
      dw_q   <= dw_d;
      bi_q   <= bi_d;
    end
  end

  always_comb begin
    ph_d     = ph_q;
    tk_d     = tk_q;
    bc_d     = bc_q;
    sb_d     = sb_q;
    crc_d    = crc_q;
    att_d    = att_q;
    code_d   = code_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    addr_d   = addr_q;
    rd_d     = rd_q;
    ff_d     = ff_q;
    dw_d     = dw_q;
    bi_d     = bi_q;
    fin      = FIN_NONE;
    do_adv   = 1'b0;
    do_load  = 1'b0;
    do_fail  = 1'b0;
    fail_end = 1'b0;
    tx_byte  = '0;
    tx_pec   = 1'b0;
    rx_byte  = '0;

    // tick counter / request latch
    if (ph_q == PH_IDLE) begin
      if (item_i.cmd == CMD_READ || item_i.cmd == CMD_WRITE) begin
        code_d = item_i.register_code;
        lo_d   = item_i.write_low;
        hi_d   = item_i.write_high;
        addr_d = item_i.slave_addr;
        rd_d   = (item_i.cmd == CMD_READ);
        ff_d   = 1'b0;
        att_d  = cfg_i.retry_limit;
        crc_d  = '0;
        bi_d   = '0;
        bc_d   = '0;
        sb_d   = '0;
        tk_d   = '0;
        ph_d   = PH_STOP0;
        do_adv = (cfg_i.phase_ticks == PHASE_W'(1));
      end
    end else if ({1'b0, tk_q} + (PHASE_W+1)'(1) < {1'b0, cfg_i.phase_ticks}) begin
      tk_d = tk_q + PHASE_W'(1);
    end else begin
      tk_d   = '0;
      do_adv = 1'b1;
    end

    if (do_adv) begin
      case (ph_d)
        PH_STOP0:  ph_d = PH_STOP1;
        PH_STOP1:  ph_d = PH_STOP2;
        PH_STOP2:  ph_d = PH_START0;
        PH_START0: ph_d = PH_START1;
        PH_START1: do_load = 1'b1;
        PH_TXLOW:  ph_d = PH_TXHIGH;
        PH_TXHIGH: begin
          sb_d = {sb_d[6:0], 1'b0};
          bc_d = bc_d + 4'd1;
          ph_d = (bc_d >= 4'd8) ? PH_ACKLOW : PH_TXLOW;
        end
        PH_ACKLOW: ph_d = PH_ACKHIGH;
        PH_ACKHIGH: begin
          if (item_i.sda_in) begin
            do_fail = 1'b1;
          end else if (rd_d) begin
            if (bi_d == 3'd0) begin
              bi_d    = 3'd1;
              do_load = 1'b1;
            end else if (bi_d == 3'd1) begin
              bi_d = 3'd2;
              ph_d = PH_RSTART;
            end else begin
              bi_d = 3'd3;
              sb_d = '0;
              bc_d = '0;
              ph_d = PH_RXLOW;
            end
          end else if (bi_d >= 3'd4) begin
            ph_d = PH_END0;
          end else begin
            bi_d    = bi_d + 3'd1;
            do_load = 1'b1;
          end
        end
        PH_RSTART: ph_d = PH_START0;
        PH_RXLOW:  ph_d = PH_RXHIGH;
        PH_RXHIGH: begin
          rx_byte = {sb_d[6:0], item_i.sda_in};
          sb_d    = rx_byte;
          bc_d    = bc_d + 4'd1;
          if (bc_d >= 4'd8) begin
            // data bytes feed the CRC; the PEC byte itself does not
            if (bi_d == 3'd3) begin
              lo_d  = rx_byte;
              crc_d = crc8_upd(crc_d, rx_byte);
            end else if (bi_d == 3'd4) begin
              hi_d  = rx_byte;
              crc_d = crc8_upd(crc_d, rx_byte);
            end
            ph_d = PH_MACKLOW;
          end else begin
            ph_d = PH_RXLOW;
          end
        end
        PH_MACKLOW: ph_d = PH_MACKHIGH;
        PH_MACKHIGH: begin
          if (bi_d < 3'd5) begin
            bi_d = bi_d + 3'd1;
            sb_d = '0;
            bc_d = '0;
            ph_d = PH_RXLOW;
          end else begin
            ph_d = PH_END0;
          end
        end
        PH_END0: ph_d = PH_END1;
        PH_END1: ph_d = PH_END2;
        PH_END2: begin
          if (ff_d) begin
            fin = FIN_FAIL;
          end else if (rd_d && (sb_d != crc_d)) begin
            do_fail  = 1'b1;
            fail_end = 1'b1;
          end else begin
            if (rd_d) dw_d = {hi_d, lo_d};
            fin = FIN_OK;
          end
        end
        default: ph_d = PH_IDLE;
      endcase

      // next byte to send
      if (do_load) begin
        case (bi_d)
          3'd0:    tx_byte = {addr_d, 1'b0};
          3'd1:    tx_byte = code_d;
          3'd2:    tx_byte = rd_d ? {addr_d, 1'b1} : lo_d;
          3'd3:    tx_byte = hi_d;
          default: begin
            tx_byte = crc_d;
            tx_pec  = 1'b1;
          end
        endcase
        sb_d = tx_byte;
        if (!tx_pec) crc_d = crc8_upd(crc_d, tx_byte);
        bc_d = '0;
        ph_d = PH_TXLOW;
      end

      // NACK or PEC mismatch: retry or give up
      if (do_fail) begin
        if (att_d <= RETRY_W'(1)) begin
          att_d = '0;
          if (fail_end) begin
            fin = FIN_FAIL;
          end else begin
            ff_d = 1'b1;
            ph_d = PH_END0;
          end
        end else begin
          att_d = att_d - RETRY_W'(1);
          crc_d = '0;
          bi_d  = '0;
          ph_d  = PH_STOP0;
        end
      end

      if (fin != FIN_NONE) ph_d = PH_IDLE;
    end
  end

  // bus drive after this tick
  always_comb begin
    res_o.scl_out = 1'b1;
    res_o.sda_out = 1'b1;
    case (ph_d)
      PH_STOP0, PH_END0: begin
        res_o.scl_out = 1'b0;
        res_o.sda_out = 1'b0;
      end
      PH_STOP1, PH_END1, PH_START1: begin
        res_o.scl_out = 1'b1;
        res_o.sda_out = 1'b0;
      end
      PH_TXLOW: begin
        res_o.scl_out = 1'b0;
        res_o.sda_out = sb_d[7];
      end
      PH_TXHIGH: begin
        res_o.scl_out = 1'b1;
        res_o.sda_out = sb_d[7];
      end
      PH_ACKLOW, PH_RXLOW, PH_RSTART: begin
        res_o.scl_out = 1'b0;
        res_o.sda_out = 1'b1;
      end
      PH_MACKLOW: begin
        res_o.scl_out = 1'b0;
        res_o.sda_out = (bi_d >= 3'd5);
      end
      PH_MACKHIGH: begin
        res_o.scl_out = 1'b1;
        res_o.sda_out = (bi_d >= 3'd5);
      end
      default: begin
        res_o.scl_out = 1'b1;
        res_o.sda_out = 1'b1;
      end
    endcase
    res_o.busy_res  = (ph_d != PH_IDLE);
    res_o.done_res  = (fin != FIN_NONE);
    res_o.failed    = (fin == FIN_FAIL);
    res_o.read_word = dw_d;
  end

endmodule

[rtl/smbus_word_master_pec_unit.sv]
// Path: a tick word passes through the input register, then the result
//   register. Throughput: one word per cycle while the output is not stalled.
// The rate is set by the sequencer state update, done once per word between
//   the input register and the result register.
// Reset (rst_ni low, async): sequencer idle, phase_ticks 20,
//   retry_limit 254, both registers empty.
module smbus_word_master_pec_unit import smbpec_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  smbpec_in_if.sink    in_i,
  smbpec_out_if.source out_o,
  smbpec_cfg_if.sink   cfg_i
);

  // input register
  logic  in_vld_q;
  item_t in_q;
  // result register
  logic    out_vld_q;
  result_t out_q;

  logic    fire;     // word moves from input reg through the sequencer
  cfg_t    cfg;
  result_t res;

  // Advance whenever the result register is empty or being drained, so a
  // word at the output that is being drained does not block the next one from entering.
  assign fire       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.cmd           <= in_i.cmd;
      in_q.slave_addr    <= in_i.slave_addr;
      in_q.register_code <= in_i.register_code;
      in_q.write_low     <= in_i.write_low;
      in_q.write_high    <= in_i.write_high;
      in_q.sda_in        <= in_i.sda_in;
    end
  end

  // config writes are to land only while idle; the block does not enforce this and is always ready
  assign cfg_i.ready = 1'b1;

  smbpec_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_i.valid),
    .index_i (cfg_i.index),
    .data_i  (cfg_i.data),
    .cfg_o   (cfg)
  );

  // sequencer state only moves on a fired word
  smbpec_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= res;
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.scl_out   = out_q.scl_out;
  assign out_o.sda_out   = out_q.sda_out;
  assign out_o.busy_res  = out_q.busy_res;
  assign out_o.done_res  = out_q.done_res;
  assign out_o.failed    = out_q.failed;
  assign out_o.read_word = out_q.read_word;

endmodule

[rtl/smbpec_chk.sv]
// Port-level checker for smbus_word_master_pec_unit, bound to the top level.
// Depends on the top level's ports only.
module smbpec_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        scl_out_i,
  input logic        sda_out_i,
  input logic        busy_res_i,
  input logic        done_res_i,
  input logic        failed_i,
  input logic [15:0] read_word_i
);

  // a transaction end leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i |-> !busy_res_i)
    else $error("done with busy still set");

  // failure is only flagged on the end word
  a_fail_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && failed_i |-> done_res_i)
    else $error("failed without done");

  // idle bus is released
  a_idle_bus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !busy_res_i |-> scl_out_i && sda_out_i)
    else $error("bus driven while idle");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_word_i)
      && $stable(scl_out_i) && $stable(sda_out_i) && $stable(busy_res_i)
      && $stable(done_res_i) && $stable(failed_i))
    else $error("stalled result word changed");

endmodule

bind smbus_word_master_pec_unit smbpec_chk u_smbpec_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .scl_out_i   (out_o.scl_out),
  .sda_out_i   (out_o.sda_out),
  .busy_res_i  (out_o.busy_res),
  .done_res_i  (out_o.done_res),
  .failed_i    (out_o.failed),
  .read_word_i (out_o.read_word)
);
